>>> src/rdi_pkg.sv
// rdi_pkg: shared types and constants for the ray / disc intersection unit
// no dependencies
package rdi_pkg;

    localparam int POS_W     = 32;
    localparam int UNIT_FRAC = 30;
    localparam int DT_W      = 36;
    localparam int QBITS     = 32;
    localparam int RAD_W     = 31;
    localparam int CFG_IDX_W = 4;

    localparam logic signed [DT_W-1:0] PAR_EPS = 36'sd1074;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X     = 4'd0,
        REG_CENTER_Y     = 4'd1,
        REG_CENTER_Z     = 4'd2,
        REG_NORMAL_X     = 4'd3,
        REG_NORMAL_Y     = 4'd4,
        REG_NORMAL_Z     = 4'd5,
        REG_DISC_RADIUS  = 4'd6,
        REG_PLANE_OFFSET = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic                    shadow;
        logic                    prior;
        logic signed [POS_W-1:0] prior_t;
        logic signed [POS_W-1:0] ox;
        logic signed [POS_W-1:0] oy;
        logic signed [POS_W-1:0] oz;
        logic signed [POS_W-1:0] dx;
        logic signed [POS_W-1:0] dy;
        logic signed [POS_W-1:0] dz;
        logic                    par;
    } t_ray;

endpackage

>>> src/ray_disc_intersect_unit.sv
// ray_disc_intersect_unit: pipelined ray / disc intersection test
// depends on rdi_pkg
//
// usage:
//  - input channel i_in_valid / o_in_stall carries one ray word: query kind,
//    origin, direction and the caller's prior hit
//  - output channel o_out_valid / i_out_stall returns one word per ray:
//    is_parallel, hit and saturated distance t
//  - config channel i_cfg_valid / o_cfg_ready writes the disc registers,
//    indexes 0..7, other indexes ignored; o_cfg_ready is always high
//  - 40 register stages between the input accept and o_out_valid, one ray per
//    cycle while the output word is not stalled
//  - the division of the plane numerator by dt takes 32 of those stages,
//    one quotient bit per stage
//  - the whole pipeline holds while the output word is stalled; o_in_stall
//    follows i_out_stall when the output register is full
//  - reset clears all valid bits and loads the default disc: center 0,
//    normal (0,0,1), radius 1.0, plane offset 0
module ray_disc_intersect_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rdi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_action,
    input  logic signed [rdi_pkg::POS_W-1:0]    i_origin_x,
    input  logic signed [rdi_pkg::POS_W-1:0]    i_origin_y,
    input  logic signed [rdi_pkg::POS_W-1:0]    i_origin_z,
    input  logic signed [rdi_pkg::POS_W-1:0]    i_dir_x,
    input  logic signed [rdi_pkg::POS_W-1:0]    i_dir_y,
    input  logic signed [rdi_pkg::POS_W-1:0]    i_dir_z,
    input  logic                                i_prior_hit,
    input  logic signed [rdi_pkg::POS_W-1:0]    i_prior_min_t,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_is_parallel,
    output logic                                o_hit,
    output logic signed [rdi_pkg::POS_W-1:0]    o_distance
);

    localparam int DW = rdi_pkg::DT_W;
    localparam int NQ = rdi_pkg::QBITS;

    logic ce;

    // config registers
    logic signed [31:0] r_cx, r_cy, r_cz, r_nx, r_ny, r_nz, r_off;
    logic [rdi_pkg::RAD_W-1:0] r_rad;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
            r_nx  <= '0;
            r_ny  <= '0;
            r_nz  <= 32'sd1073741824;
            r_rad <= 31'd65536;
            r_off <= '0;
        end else if (i_cfg_valid) begin
            case (rdi_pkg::t_reg_idx'(i_cfg_index))
                rdi_pkg::REG_CENTER_X:     r_cx  <= i_cfg_data;
                rdi_pkg::REG_CENTER_Y:     r_cy  <= i_cfg_data;
                rdi_pkg::REG_CENTER_Z:     r_cz  <= i_cfg_data;
                rdi_pkg::REG_NORMAL_X:     r_nx  <= i_cfg_data;
                rdi_pkg::REG_NORMAL_Y:     r_ny  <= i_cfg_data;
                rdi_pkg::REG_NORMAL_Z:     r_nz  <= i_cfg_data;
                rdi_pkg::REG_DISC_RADIUS:  r_rad <= i_cfg_data[rdi_pkg::RAD_W-1:0];
                rdi_pkg::REG_PLANE_OFFSET: r_off <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits
    logic r_v1, r_v2, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic r_dvld [0:NQ];

    assign ce         = !r_v8 || !i_out_stall;
    assign o_in_stall = !ce;

    // stage 1: dot product terms
    rdi_pkg::t_ray r_ray1;
    logic signed [63:0] r_dp0, r_dp1, r_dp2, r_op0, r_op1, r_op2;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dp0 <= 64'(i_dir_x) * 64'(r_nx);
            r_dp1 <= 64'(i_dir_y) * 64'(r_ny);
            r_dp2 <= 64'(i_dir_z) * 64'(r_nz);
            r_op0 <= 64'(r_nx) * 64'(i_origin_x);
            r_op1 <= 64'(r_ny) * 64'(i_origin_y);
            r_op2 <= 64'(r_nz) * 64'(i_origin_z);
            r_ray1.shadow  <= i_action;
            r_ray1.prior   <= i_prior_hit;
            r_ray1.prior_t <= i_prior_min_t;
            r_ray1.ox      <= i_origin_x;
            r_ray1.oy      <= i_origin_y;
            r_ray1.oz      <= i_origin_z;
            r_ray1.dx      <= i_dir_x;
            r_ray1.dy      <= i_dir_y;
            r_ray1.dz      <= i_dir_z;
            r_ray1.par     <= 1'b0;
        end
    end

    // stage 2: dt, numerator, parallel test
    rdi_pkg::t_ray r_ray2;
    rdi_pkg::t_ray n_ray2;
    logic signed [DW-1:0] r_dt, r_num;
    logic signed [DW-1:0] n_dt, n_num;
    logic signed [63:0]   n_osum;

    always_comb begin
        n_dt   = DW'((r_dp0 >>> rdi_pkg::UNIT_FRAC) + (r_dp1 >>> rdi_pkg::UNIT_FRAC)
                   + (r_dp2 >>> rdi_pkg::UNIT_FRAC));
        n_osum = (r_op0 >>> rdi_pkg::UNIT_FRAC) + (r_op1 >>> rdi_pkg::UNIT_FRAC)
               + (r_op2 >>> rdi_pkg::UNIT_FRAC);
        n_num  = DW'(64'(r_off) - n_osum);
        n_ray2     = r_ray1;
        n_ray2.par = (n_dt < rdi_pkg::PAR_EPS) && (n_dt > -rdi_pkg::PAR_EPS);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dt   <= n_dt;
            r_num  <= n_num;
            r_ray2 <= n_ray2;
        end
    end

    // stage 3: magnitudes, overflow check, divider setup
    logic [DW-1:0]  r_dr   [0:NQ];
    logic [NQ-1:0]  r_dq   [0:NQ];
    logic [DW-1:0]  r_dd   [0:NQ];
    logic [1:0]     r_dnlo [0:NQ];
    logic           r_dneg [0:NQ];
    logic           r_dovf [0:NQ];
    rdi_pkg::t_ray  r_dray [0:NQ];
    logic [DW-1:0]  n_nmag, n_dmag;

    always_comb begin
        n_nmag = r_num[DW-1] ? DW'(-r_num) : DW'(r_num);
        n_dmag = r_dt[DW-1]  ? DW'(-r_dt)  : DW'(r_dt);
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_dr[0]   <= n_nmag >> 2;
            r_dq[0]   <= '0;
            r_dd[0]   <= n_dmag;
            r_dnlo[0] <= n_nmag[1:0];
            r_dneg[0] <= r_num[DW-1] ^ r_dt[DW-1];
            r_dovf[0] <= {2'b00, n_nmag} >= {n_dmag, 2'b00};
            r_dray[0] <= r_ray2;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < NQ; k++) begin : g_div
        logic          nb;
        logic [DW:0]   trial;

        always_comb begin
            if (k == 0) begin
                nb = r_dnlo[k][1];
            end else if (k == 1) begin
                nb = r_dnlo[k][0];
            end else begin
                nb = 1'b0;
            end
            trial = {r_dr[k], nb} - {1'b0, r_dd[k]};
        end

        always_ff @(posedge i_clk) begin
            if (ce) begin
                if (!trial[DW]) begin
                    r_dr[k+1] <= trial[DW-1:0];
                    r_dq[k+1] <= {r_dq[k][NQ-2:0], 1'b1};
                end else begin
                    r_dr[k+1] <= {r_dr[k][DW-2:0], nb};
                    r_dq[k+1] <= {r_dq[k][NQ-2:0], 1'b0};
                end
                r_dd[k+1]   <= r_dd[k];
                r_dnlo[k+1] <= r_dnlo[k];
                r_dneg[k+1] <= r_dneg[k];
                r_dovf[k+1] <= r_dovf[k];
                r_dray[k+1] <= r_dray[k];
            end
        end
    end

    // stage 4: saturate t, prior hit test
    rdi_pkg::t_ray r_ray4;
    logic signed [31:0] r_t, n_t;
    logic r_miss4;

    always_comb begin
        if (r_dovf[NQ] || r_dq[NQ][NQ-1]) begin
            n_t = r_dneg[NQ] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            n_t = r_dneg[NQ] ? -$signed(r_dq[NQ]) : $signed(r_dq[NQ]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_t     <= n_t;
            r_ray4  <= r_dray[NQ];
            r_miss4 <= !r_dray[NQ].shadow && r_dray[NQ].prior && (n_t > r_dray[NQ].prior_t);
        end
    end

    // stage 5: direction times t
    rdi_pkg::t_ray r_ray5;
    logic signed [31:0] r_t5;
    logic r_miss5;
    logic signed [63:0] r_pm0, r_pm1, r_pm2;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_pm0   <= 64'(r_ray4.dx) * 64'(r_t);
            r_pm1   <= 64'(r_ray4.dy) * 64'(r_t);
            r_pm2   <= 64'(r_ray4.dz) * 64'(r_t);
            r_t5    <= r_t;
            r_ray5  <= r_ray4;
            r_miss5 <= r_miss4;
        end
    end

    // stage 6: hit point offset from center, box reject
    logic signed [31:0] r_t6;
    logic r_miss6, r_par6, r_far6;
    logic [rdi_pkg::RAD_W-1:0] r_m0, r_m1, r_m2;
    logic signed [34:0] n_e0, n_e1, n_e2;
    logic [34:0] n_a0, n_a1, n_a2;
    logic n_far;

    always_comb begin
        n_e0 = 35'(r_ray5.ox) + 35'(r_pm0 >>> rdi_pkg::UNIT_FRAC) - 35'(r_cx);
        n_e1 = 35'(r_ray5.oy) + 35'(r_pm1 >>> rdi_pkg::UNIT_FRAC) - 35'(r_cy);
        n_e2 = 35'(r_ray5.oz) + 35'(r_pm2 >>> rdi_pkg::UNIT_FRAC) - 35'(r_cz);
        n_a0 = n_e0[34] ? 35'(-n_e0) : 35'(n_e0);
        n_a1 = n_e1[34] ? 35'(-n_e1) : 35'(n_e1);
        n_a2 = n_e2[34] ? 35'(-n_e2) : 35'(n_e2);
        n_far = (n_a0 >= 35'(r_rad)) || (n_a1 >= 35'(r_rad)) || (n_a2 >= 35'(r_rad));
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_m0    <= n_a0[rdi_pkg::RAD_W-1:0];
            r_m1    <= n_a1[rdi_pkg::RAD_W-1:0];
            r_m2    <= n_a2[rdi_pkg::RAD_W-1:0];
            r_far6  <= n_far;
            r_t6    <= r_t5;
            r_par6  <= r_ray5.par;
            r_miss6 <= r_miss5;
        end
    end

    // stage 7: squares
    logic signed [31:0] r_t7;
    logic r_miss7, r_par7, r_far7;
    logic [61:0] r_sq0, r_sq1, r_sq2, r_r2;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_sq0   <= 62'(r_m0) * 62'(r_m0);
            r_sq1   <= 62'(r_m1) * 62'(r_m1);
            r_sq2   <= 62'(r_m2) * 62'(r_m2);
            r_r2    <= 62'(r_rad) * 62'(r_rad);
            r_t7    <= r_t6;
            r_par7  <= r_par6;
            r_miss7 <= r_miss6;
            r_far7  <= r_far6;
        end
    end

    // stage 8: output register
    logic r_hit8, r_par8;
    logic signed [31:0] r_dist8;
    logic [63:0] n_sum;

    assign n_sum = 64'(r_sq0) + 64'(r_sq1) + 64'(r_sq2);

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_par8  <= r_par7;
            r_hit8  <= !r_par7 && !r_miss7 && !r_far7 && (n_sum < 64'(r_r2));
            r_dist8 <= r_par7 ? '0 : r_t7;
        end
    end

    assign o_out_valid   = r_v8;
    assign o_is_parallel = r_par8;
    assign o_hit         = r_hit8;
    assign o_distance    = r_dist8;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            for (int j = 0; j <= NQ; j++) begin
                r_dvld[j] <= 1'b0;
            end
        end else if (ce) begin
            r_v1      <= i_in_valid;
            r_v2      <= r_v1;
            r_dvld[0] <= r_v2;
            for (int j = 0; j < NQ; j++) begin
                r_dvld[j+1] <= r_dvld[j];
            end
            r_v4 <= r_dvld[NQ];
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

endmodule
